### sv/selective_repeat_send_window_defines.svh
// Assertion macros for the selective-repeat send window.
// Included by the top level; depends on nothing else.
`ifndef SELECTIVE_REPEAT_SEND_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_SEND_WINDOW_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define SRSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define SRSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SRSW_ASSERT_NOW(lbl, ante, cons, msg)
`define SRSW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### sv/srsw_pkg.sv
// Shared types and constants of the selective-repeat send window.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package srsw_pkg;

  // field widths fixed by the word formats
  localparam int CMD_W      = 1;
  localparam int NUM_W      = 11;
  localparam int EV_W       = 3;
  localparam int SEQ_W      = 10;
  localparam int BASE_W     = 11;
  localparam int WSIZE_W    = 6;
  localparam int PCOUNT_W   = 11;
  localparam int RETRY_W    = 7;
  localparam int WINW       = 7;   // effective window, up to 63 and at most WINDOW_MAX
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // commands
  localparam logic [CMD_W-1:0] CMD_ACK  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

  // result event codes
  localparam logic [EV_W-1:0] EV_SEND      = 3'd0;
  localparam logic [EV_W-1:0] EV_ACK_OK    = 3'd1;
  localparam logic [EV_W-1:0] EV_BAD_CHECK = 3'd2;
  localparam logic [EV_W-1:0] EV_RANGE     = 3'd3;
  localparam logic [EV_W-1:0] EV_COMPLETE  = 3'd4;
  localparam logic [EV_W-1:0] EV_UNREACH   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 2'd2;

  // configuration reset values
  localparam logic [WSIZE_W-1:0]  WINDOW_SIZE_RST  = 6'd10;
  localparam logic [PCOUNT_W-1:0] PACKET_COUNT_RST = 11'd0;
  localparam logic [RETRY_W-1:0]  RETRY_LIMIT_RST  = 7'd100;

  // retry count of a packet after its first send
  localparam logic [RETRY_W-1:0] RETRY_FIRST = 7'd1;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [NUM_W-1:0] ack_number;
    logic             ack_kind;
    logic [NUM_W-1:0] ack_check;
  } in_word_t;

  typedef struct packed {
    logic [EV_W-1:0]   event_res;
    logic [SEQ_W-1:0]  seq_number;
    logic [BASE_W-1:0] window_base;
    logic              last;
  } out_word_t;

endpackage

### sv/srsw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module srsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/selective_repeat_send_window.sv
// Selective-repeat send window: ack bookkeeping, window slide, resend on tick.
// Depends on srsw_pkg, srsw_ram and selective_repeat_send_window_defines.svh.
// Walk: an item steps one entry per cycle on the acked-map read port (slide, tick resend
//   and admission).
// Results come at most one a cycle; each is held until the next one exists, last on the final one.
// Reset: a clearing pass writes every acked-map entry, busy high.
`timescale 1ns / 1ps
`include "selective_repeat_send_window_defines.svh"

module selective_repeat_send_window #(
  parameter int MAX_PACKETS = 1024,
  parameter int WINDOW_MAX  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  srsw_pkg::in_word_t                  in_word,
  // result channel
  output logic                                out_valid,
  output srsw_pkg::out_word_t                 out_word,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CW   = $clog2(MAX_PACKETS + 1);
  localparam int AW   = $clog2(MAX_PACKETS);
  localparam int PW   = (CW > srsw_pkg::NUM_W) ? CW : srsw_pkg::NUM_W;
  localparam int SUMW = PW + 1;
  localparam int SW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_SLIDE = 3'd3;
  localparam logic [2:0] S_TICK  = 3'd4;
  localparam logic [2:0] S_ADM0  = 3'd5;
  localparam logic [2:0] S_ADM   = 3'd6;
  localparam logic [2:0] S_FLUSH = 3'd7;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    if (s == SW'(WINDOW_MAX - 1)) begin
      slot_inc = '0;
    end else begin
      slot_inc = s + SW'(1);
    end
  endfunction

  // control and bookkeeping registers
  logic [2:0]                          state_r, state_nxt;
  logic [AW-1:0]                       clr_r, clr_nxt;
  srsw_pkg::in_word_t                  in_r, in_nxt;
  logic [CW-1:0]                       ws_r, ws_nxt;
  logic [CW-1:0]                       nts_r, nts_nxt;
  logic [CW-1:0]                       p_r, p_nxt;
  logic [SW-1:0]                       ws_slot_r, ws_slot_nxt;
  logic [SW-1:0]                       nts_slot_r, nts_slot_nxt;
  logic [SW-1:0]                       p_slot_r, p_slot_nxt;
  logic                                finished_r, finished_nxt;
  logic                                gave_up_r, gave_up_nxt;
  logic                                pend_v_r, pend_v_nxt;
  logic [srsw_pkg::EV_W-1:0]           pend_ev_r, pend_ev_nxt;
  logic [srsw_pkg::SEQ_W-1:0]          pend_seq_r, pend_seq_nxt;
  logic                                out_valid_r, out_valid_nxt;
  srsw_pkg::out_word_t                 out_word_r, out_word_nxt;
  logic [srsw_pkg::WSIZE_W-1:0]        win_size_r;
  logic [srsw_pkg::PCOUNT_W-1:0]       pkt_count_r;
  logic [srsw_pkg::RETRY_W-1:0]        retry_limit_r;

  // memory ports
  logic                                ack_we;
  logic [AW-1:0]                       ack_waddr, ack_raddr;
  logic [0:0]                          ack_wdata, ack_rdata;
  logic                                rty_we;
  logic [SW-1:0]                       rty_waddr, rty_raddr;
  logic [srsw_pkg::RETRY_W-1:0]        rty_wdata, rty_rdata;

  // derived values
  logic [CW-1:0]                       pc_eff;
  logic [PW-1:0]                       pkt_ext, num_ext, ws_ext;
  logic [srsw_pkg::WINW-1:0]           win_ext, win_eff;
  logic [SUMW-1:0]                     ws_plus_win;
  logic [CW-1:0]                       ws_inc, nts_inc, p_inc;
  logic                                chk_ok;
  logic                                emit_en;
  logic [srsw_pkg::EV_W-1:0]           emit_ev;
  logic [srsw_pkg::SEQ_W-1:0]          emit_seq;

  srsw_ram #(.WIDTH(1), .DEPTH(MAX_PACKETS)) u_acked_ram (
    .clk   (clk),
    .we    (ack_we),
    .waddr (ack_waddr),
    .wdata (ack_wdata),
    .raddr (ack_raddr),
    .rdata (ack_rdata)
  );

  srsw_ram #(.WIDTH(srsw_pkg::RETRY_W), .DEPTH(WINDOW_MAX)) u_retry_ram (
    .clk   (clk),
    .we    (rty_we),
    .waddr (rty_waddr),
    .wdata (rty_wdata),
    .raddr (rty_raddr),
    .rdata (rty_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // clamp packet count and window size
  always_comb begin
    pkt_ext = PW'(pkt_count_r);
    if (pkt_ext > PW'(MAX_PACKETS)) begin
      pc_eff = CW'(MAX_PACKETS);
    end else begin
      pc_eff = pkt_ext[CW-1:0];
    end
    win_ext = srsw_pkg::WINW'(win_size_r);
    if (win_ext == '0) begin
      win_eff = srsw_pkg::WINW'(1);
    end else if (win_ext > srsw_pkg::WINW'(WINDOW_MAX)) begin
      win_eff = srsw_pkg::WINW'(WINDOW_MAX);
    end else begin
      win_eff = win_ext;
    end
  end

  assign num_ext     = PW'(in_r.ack_number);
  assign ws_ext      = PW'(ws_r);
  assign ws_plus_win = SUMW'(ws_r) + SUMW'(win_eff);
  assign ws_inc      = ws_r + CW'(1);
  assign nts_inc     = nts_r + CW'(1);
  assign p_inc       = p_r + CW'(1);
  assign chk_ok      = (in_r.ack_check ==
                        (in_r.ack_number ^ srsw_pkg::NUM_W'(in_r.ack_kind)));

  // sequencer: one map entry per cycle, each read issued in the cycle before its data is used
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    in_nxt        = in_r;
    ws_nxt        = ws_r;
    nts_nxt       = nts_r;
    p_nxt         = p_r;
    ws_slot_nxt   = ws_slot_r;
    nts_slot_nxt  = nts_slot_r;
    p_slot_nxt    = p_slot_r;
    finished_nxt  = finished_r;
    gave_up_nxt   = gave_up_r;
    pend_v_nxt    = pend_v_r;
    pend_ev_nxt   = pend_ev_r;
    pend_seq_nxt  = pend_seq_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    ack_we        = 1'b0;
    ack_waddr     = clr_r;
    ack_wdata     = 1'b0;
    ack_raddr     = ws_r[AW-1:0];
    rty_we        = 1'b0;
    rty_waddr     = nts_slot_r;
    rty_wdata     = srsw_pkg::RETRY_FIRST;
    rty_raddr     = ws_slot_r;
    emit_en       = 1'b0;
    emit_ev       = srsw_pkg::EV_SEND;
    emit_seq      = '0;

    unique case (state_r)
      S_CLEAR: begin
        ack_we    = 1'b1;
        ack_waddr = clr_r;
        ack_wdata = 1'b0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(MAX_PACKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          in_nxt    = in_word;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (gave_up_r || finished_r) begin
          emit_en   = 1'b1;
          emit_ev   = gave_up_r ? srsw_pkg::EV_UNREACH : srsw_pkg::EV_COMPLETE;
          state_nxt = S_FLUSH;
        end else if (in_r.command == srsw_pkg::CMD_ACK) begin
          if (!chk_ok) begin
            emit_en   = 1'b1;
            emit_ev   = srsw_pkg::EV_BAD_CHECK;
            emit_seq  = in_r.ack_number[srsw_pkg::SEQ_W-1:0];
            state_nxt = S_ADM0;
          end else if (num_ext >= PW'(pc_eff)) begin
            emit_en   = 1'b1;
            emit_ev   = srsw_pkg::EV_RANGE;
            emit_seq  = in_r.ack_number[srsw_pkg::SEQ_W-1:0];
            state_nxt = S_ADM0;
          end else begin
            ack_we    = 1'b1;
            ack_waddr = num_ext[AW-1:0];
            ack_wdata = 1'b1;
            if (ws_ext == num_ext) begin
              // base itself just got acked: step past it and start the slide
              ws_nxt      = ws_inc;
              ws_slot_nxt = slot_inc(ws_slot_r);
              ack_raddr   = ws_inc[AW-1:0];
              state_nxt   = S_SLIDE;
            end else begin
              emit_en   = 1'b1;
              emit_ev   = srsw_pkg::EV_ACK_OK;
              emit_seq  = in_r.ack_number[srsw_pkg::SEQ_W-1:0];
              state_nxt = S_ADM0;
            end
          end
        end else begin
          ack_raddr  = ws_r[AW-1:0];
          rty_raddr  = ws_slot_r;
          p_nxt      = ws_r;
          p_slot_nxt = ws_slot_r;
          state_nxt  = S_TICK;
        end
      end
      S_SLIDE: begin
        if ((ws_r < pc_eff) && ack_rdata[0]) begin
          ws_nxt      = ws_inc;
          ws_slot_nxt = slot_inc(ws_slot_r);
          ack_raddr   = ws_inc[AW-1:0];
        end else begin
          if (nts_r < ws_r) begin
            nts_nxt      = ws_r;
            nts_slot_nxt = ws_slot_r;
          end
          emit_en   = 1'b1;
          emit_ev   = srsw_pkg::EV_ACK_OK;
          emit_seq  = in_r.ack_number[srsw_pkg::SEQ_W-1:0];
          state_nxt = S_ADM0;
        end
      end
      S_TICK: begin
        if ((p_r < nts_r) && (p_r < pc_eff)) begin
          p_nxt      = p_inc;
          p_slot_nxt = slot_inc(p_slot_r);
          ack_raddr  = p_inc[AW-1:0];
          rty_raddr  = slot_inc(p_slot_r);
          if (!ack_rdata[0]) begin
            if (rty_rdata >= retry_limit_r) begin
              emit_en     = 1'b1;
              emit_ev     = srsw_pkg::EV_UNREACH;
              emit_seq    = PW'(p_r) >> 0 == '0 ? '0 : srsw_pkg::SEQ_W'(p_r);
              gave_up_nxt = 1'b1;
              state_nxt   = S_FLUSH;
            end else begin
              rty_we    = 1'b1;
              rty_waddr = p_slot_r;
              rty_wdata = rty_rdata + srsw_pkg::RETRY_W'(1);
              emit_en   = 1'b1;
              emit_ev   = srsw_pkg::EV_SEND;
              emit_seq  = srsw_pkg::SEQ_W'(p_r);
            end
          end
        end else begin
          state_nxt = S_ADM0;
        end
      end
      S_ADM0: begin
        ack_raddr = nts_r[AW-1:0];
        state_nxt = S_ADM;
      end
      S_ADM: begin
        if ((SUMW'(nts_r) < ws_plus_win) && (nts_r < pc_eff)) begin
          if (!ack_rdata[0]) begin
            rty_we    = 1'b1;
            rty_waddr = nts_slot_r;
            rty_wdata = srsw_pkg::RETRY_FIRST;
            emit_en   = 1'b1;
            emit_ev   = srsw_pkg::EV_SEND;
            emit_seq  = srsw_pkg::SEQ_W'(nts_r);
          end
          nts_nxt      = nts_inc;
          nts_slot_nxt = slot_inc(nts_slot_r);
          ack_raddr    = nts_inc[AW-1:0];
        end else begin
          if (ws_r >= pc_eff) begin
            emit_en      = 1'b1;
            emit_ev      = srsw_pkg::EV_COMPLETE;
            finished_nxt = 1'b1;
          end
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // held word is the final one of the item
        if (pend_v_r) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.event_res   = pend_ev_r;
          out_word_nxt.seq_number  = pend_seq_r;
          out_word_nxt.window_base = ws_ext[srsw_pkg::BASE_W-1:0];
          out_word_nxt.last        = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // one-word hold: a word goes out once the next one exists
    if (emit_en) begin
      if (pend_v_r) begin
        out_valid_nxt            = 1'b1;
        out_word_nxt.event_res   = pend_ev_r;
        out_word_nxt.seq_number  = pend_seq_r;
        out_word_nxt.window_base = ws_ext[srsw_pkg::BASE_W-1:0];
        out_word_nxt.last        = 1'b0;
      end
      pend_v_nxt   = 1'b1;
      pend_ev_nxt  = emit_ev;
      pend_seq_nxt = emit_seq;
    end
  end

  // configuration writes, taken in any state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r    <= srsw_pkg::WINDOW_SIZE_RST;
      pkt_count_r   <= srsw_pkg::PACKET_COUNT_RST;
      retry_limit_r <= srsw_pkg::RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        srsw_pkg::CFG_WINDOW_SIZE:  win_size_r    <= cfg_wdata[srsw_pkg::WSIZE_W-1:0];
        srsw_pkg::CFG_PACKET_COUNT: pkt_count_r   <= cfg_wdata[srsw_pkg::PCOUNT_W-1:0];
        srsw_pkg::CFG_RETRY_LIMIT:  retry_limit_r <= cfg_wdata[srsw_pkg::RETRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ws_r        <= '0;
      nts_r       <= '0;
      ws_slot_r   <= '0;
      nts_slot_r  <= '0;
      finished_r  <= 1'b0;
      gave_up_r   <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ws_r        <= ws_nxt;
      nts_r       <= nts_nxt;
      ws_slot_r   <= ws_slot_nxt;
      nts_slot_r  <= nts_slot_nxt;
      finished_r  <= finished_nxt;
      gave_up_r   <= gave_up_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    p_r        <= p_nxt;
    p_slot_r   <= p_slot_nxt;
    pend_ev_r  <= pend_ev_nxt;
    pend_seq_r <= pend_seq_nxt;
    out_word_r <= out_word_nxt;
  end

  // checks
  `SRSW_ASSERT_NOW(a_idle_order, state_r == S_IDLE, nts_r >= ws_r, "send pointer behind base")
  `SRSW_ASSERT_NOW(a_last_drains, out_valid && out_word.last, !pend_v_r, "word left after last")
  `SRSW_ASSERT_NOW(a_unreach_flag, out_valid && out_word.event_res == srsw_pkg::EV_UNREACH, gave_up_r, "unreachable without give-up")
  `SRSW_ASSERT_NEXT(a_gave_up_sticky, gave_up_r, gave_up_r, "give-up flag dropped")

endmodule
